// ----- rtl/probe_reply_tracking_table_core_macros.svh -----
// assertion macros shared by the probe reply tracking table rtl
`ifndef PROBE_REPLY_TRACKING_TABLE_CORE_MACROS_SVH
`define PROBE_REPLY_TRACKING_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PRTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled while in reset
`define PRTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- rtl/prtt_pkg.sv -----
// types, codes and constants of the probe reply tracking table
`default_nettype none

package prtt_pkg;

    // table geometry and field widths
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ADDR_W          = 32;
    localparam int TICK_W          = 32;
    localparam int LEN_W           = 16;
    localparam int TYPE_W          = 8;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    // register reset values
    localparam logic [TICK_W-1:0] TIMEOUT_RESET   = 32'd1000;
    localparam logic [LEN_W-1:0]  REPLY_LEN_RESET = 16'd28;

    // register indexes, taken from paddr bit 2
    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_REPLY_LEN = 1'b1;

    // echo reply icmp type
    localparam logic [TYPE_W-1:0] ICMP_ECHO_REPLY = 8'd0;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REPLY  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // entry status codes
    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_ONLINE  = 2'd1,
        ST_OFFLINE = 2'd2
    } status_t;

    // result kinds
    localparam logic KIND_RETIRED = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_DRAIN
    } state_t;

    // input beat
    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] host_address;
        logic [LEN_W-1:0]  reply_length;
        logic [TYPE_W-1:0] reply_type;
    } item_t;

    // result beat
    typedef struct packed {
        logic              result_kind;
        logic [ADDR_W-1:0] retired_address;
        logic              host_online;
        logic              last;
    } result_t;

    // contents of one table cell
    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [ADDR_W-1:0] address;
        logic [TICK_W-1:0] stamp;
    } entry_t;

    // broadcast control from the controller to every cell
    typedef struct packed {
        logic              clear;
        logic              shift;
        logic              insert;
        logic              load;
        logic              apply;
        logic              reply_check;
        logic              tick_check;
        logic              reply_online;
        logic [ADDR_W-1:0] host_address;
        logic [TICK_W-1:0] tick_now;
        logic [TICK_W-1:0] tick_next;
        logic [TICK_W-1:0] timeout;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/prtt_cell.sv -----
// one table cell: holds one entry, shifts towards the head, resolves reply matches
`default_nettype none

module prtt_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire prtt_pkg::cell_ctrl_t ctrl,
    input  wire prtt_pkg::entry_t     next_entry,
    input  wire logic                 prev_valid,
    input  wire logic                 tok_in,
    output logic                      tok_out,
    output prtt_pkg::entry_t          entry
);

    logic                          valid_reg, valid_next;
    prtt_pkg::status_t             status_reg, status_next;
    logic [prtt_pkg::ADDR_W-1:0]   address_reg, address_next;
    logic [prtt_pkg::TICK_W-1:0]   stamp_reg, stamp_next;
    logic                          hit_reg, hit_next;
    logic                          expire_reg, expire_next;
    logic [prtt_pkg::TICK_W-1:0]   age;
    logic                          take;

    // first-match token passed along the row, oldest cell first
    assign take    = hit_reg & ~tok_in;
    assign tok_out = tok_in | hit_reg;

    assign age = ctrl.tick_next - stamp_reg;

    // next cell contents
    always_comb
    begin
        valid_next   = valid_reg;
        status_next  = status_reg;
        address_next = address_reg;
        stamp_next   = stamp_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next   = next_entry.valid;
            status_next  = next_entry.status;
            address_next = next_entry.address;
            stamp_next   = next_entry.stamp;
        end
        else if (ctrl.insert && !valid_reg && prev_valid)
        begin
            valid_next   = 1'b1;
            status_next  = prtt_pkg::ST_PENDING;
            address_next = ctrl.host_address;
            stamp_next   = ctrl.tick_now;
        end
        else if (ctrl.apply && status_reg == prtt_pkg::ST_PENDING)
        begin
            if (take)
            begin
                status_next = ctrl.reply_online ? prtt_pkg::ST_ONLINE : prtt_pkg::ST_OFFLINE;
            end
            else if (expire_reg)
            begin
                status_next = prtt_pkg::ST_OFFLINE;
            end
        end
    end

    // per-cell compare, registered ahead of the update
    always_comb
    begin
        hit_next    = hit_reg;
        expire_next = expire_reg;
        if (ctrl.load)
        begin
            hit_next    = ctrl.reply_check & valid_reg & (address_reg == ctrl.host_address);
            expire_next = ctrl.tick_check & valid_reg & (age >= ctrl.timeout);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= prtt_pkg::ST_PENDING;
        end
        else
        begin
            valid_reg  <= valid_next;
            status_reg <= status_next;
        end
    end

    // payload and compare flags
    always_ff @(posedge clk)
    begin
        address_reg <= address_next;
        stamp_reg   <= stamp_next;
        hit_reg     <= hit_next;
        expire_reg  <= expire_next;
    end

    assign entry.valid   = valid_reg;
    assign entry.status  = status_reg;
    assign entry.address = address_reg;
    assign entry.stamp   = stamp_reg;

endmodule

`default_nettype wire

// ----- rtl/prtt_regs.sv -----
// apb register file: timeout and expected reply length
`default_nettype none

module prtt_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [prtt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [prtt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [prtt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output logic      [prtt_pkg::TICK_W-1:0]        timeout,
    output logic      [prtt_pkg::LEN_W-1:0]         reply_len
);

    logic [prtt_pkg::TICK_W-1:0] timeout_reg, timeout_next;
    logic [prtt_pkg::LEN_W-1:0]  reply_len_reg, reply_len_next;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // write decode
    always_comb
    begin
        timeout_next   = timeout_reg;
        reply_len_next = reply_len_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                prtt_pkg::REG_TIMEOUT:   timeout_next   = pwdata;
                prtt_pkg::REG_REPLY_LEN: reply_len_next = pwdata[prtt_pkg::LEN_W-1:0];
                default:                 timeout_next   = timeout_reg;
            endcase
        end
    end

    // read decode
    always_comb
    begin
        unique case (paddr[2])
            prtt_pkg::REG_TIMEOUT:   prdata = timeout_reg;
            prtt_pkg::REG_REPLY_LEN: prdata = {{(prtt_pkg::CFG_DATA_W-prtt_pkg::LEN_W){1'b0}},
                                               reply_len_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= prtt_pkg::TIMEOUT_RESET;
            reply_len_reg <= prtt_pkg::REPLY_LEN_RESET;
        end
        else
        begin
            timeout_reg   <= timeout_next;
            reply_len_reg <= reply_len_next;
        end
    end

    assign timeout   = timeout_reg;
    assign reply_len = reply_len_reg;

endmodule

`default_nettype wire

// ----- rtl/probe_reply_tracking_table_core.sv -----
// Probe reply tracking table. Entries sit in a row of cells in send order, the
// oldest in cell 0; retiring shifts the whole row one cell towards the head.
// Insert and clear update the cells at the end of the accept cycle, and a refused
// insert shows its result beat in the following cycle. For reply and tick the
// cells compare in the accept cycle and update in the next, then settled entries
// retire from the head in send order; busy stays high while the cells update and
// while settled entries retire. Result beats of one item come on
// consecutive cycles, the final one marked by last; the receiver cannot stall,
// so it must take every beat in the cycle that result_strobe is high.
`default_nettype none

`include "probe_reply_tracking_table_core_macros.svh"

module probe_reply_tracking_table_core #(
    parameter int TABLE_DEPTH = prtt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire prtt_pkg::item_t                    item,
    output prtt_pkg::result_t                       result,
    output logic                                    result_strobe,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [prtt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [prtt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [prtt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    prtt_pkg::state_t            state_reg, state_next;
    prtt_pkg::result_t           result_reg, result_next;
    logic                        strobe_reg, strobe_next;
    logic [prtt_pkg::TICK_W-1:0] tick_now_reg, tick_now_next;
    logic                        reply_online_reg, reply_online_next;
    logic [prtt_pkg::TICK_W-1:0] timeout;
    logic [prtt_pkg::LEN_W-1:0]  reply_len;
    prtt_pkg::cell_ctrl_t        ctrl;
    prtt_pkg::entry_t            cell_q [TABLE_DEPTH];
    logic                        tok [TABLE_DEPTH+1];
    logic                        head_settled;
    logic                        next_settled;
    logic                        full;
    logic                        accept;

    // configuration registers
    prtt_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .timeout   (timeout),
        .reply_len (reply_len)
    );

    // row of cells, cell 0 at the head
    assign tok[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        prtt_pkg::entry_t nb_entry;
        logic             nb_valid;

        if (g == TABLE_DEPTH - 1)
        begin : g_tail
            assign nb_entry = '0;
        end
        else
        begin : g_body
            assign nb_entry = cell_q[g+1];
        end

        if (g == 0)
        begin : g_first
            assign nb_valid = 1'b1;
        end
        else
        begin : g_rest
            assign nb_valid = cell_q[g-1].valid;
        end

        prtt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .next_entry (nb_entry),
            .prev_valid (nb_valid),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1]),
            .entry      (cell_q[g])
        );
    end

    // head status
    assign head_settled = cell_q[0].valid && (cell_q[0].status != prtt_pkg::ST_PENDING);
    assign next_settled = cell_q[1].valid && (cell_q[1].status != prtt_pkg::ST_PENDING);
    assign full         = cell_q[TABLE_DEPTH-1].valid;

    assign busy   = !((state_reg == prtt_pkg::S_IDLE) ||
                      (state_reg == prtt_pkg::S_DRAIN && !head_settled));
    assign accept = start & ~busy;

    // sequencer: next state, cell control and result beat
    always_comb
    begin
        state_next           = state_reg;
        result_next          = result_reg;
        strobe_next          = 1'b0;
        tick_now_next        = tick_now_reg;
        reply_online_next    = reply_online_reg;
        ctrl                 = '0;
        ctrl.host_address    = item.host_address;
        ctrl.tick_now        = tick_now_reg;
        ctrl.tick_next       = tick_now_reg + {{(prtt_pkg::TICK_W-1){1'b0}}, 1'b1};
        ctrl.timeout         = timeout;
        ctrl.reply_online    = reply_online_reg;
        unique case (state_reg) inside
            prtt_pkg::S_IDLE, prtt_pkg::S_DRAIN:
            begin
                if (state_reg == prtt_pkg::S_DRAIN && head_settled)
                begin
                    // retire the head and move the row up
                    ctrl.shift                  = 1'b1;
                    strobe_next                 = 1'b1;
                    result_next.result_kind     = prtt_pkg::KIND_RETIRED;
                    result_next.retired_address = cell_q[0].address;
                    result_next.host_online     = (cell_q[0].status == prtt_pkg::ST_ONLINE);
                    result_next.last            = !next_settled;
                end
                else
                begin
                    state_next = prtt_pkg::S_IDLE;
                    if (accept)
                    begin
                        unique case (item.command)
                            prtt_pkg::CMD_INSERT:
                            begin
                                if (full)
                                begin
                                    strobe_next                 = 1'b1;
                                    result_next.result_kind     = prtt_pkg::KIND_REFUSED;
                                    result_next.retired_address = item.host_address;
                                    result_next.host_online     = 1'b0;
                                    result_next.last            = 1'b1;
                                end
                                else
                                begin
                                    ctrl.insert = 1'b1;
                                end
                            end
                            prtt_pkg::CMD_REPLY:
                            begin
                                ctrl.load         = 1'b1;
                                ctrl.reply_check  = (item.reply_length == reply_len);
                                reply_online_next = (item.reply_type == prtt_pkg::ICMP_ECHO_REPLY);
                                state_next        = prtt_pkg::S_APPLY;
                            end
                            prtt_pkg::CMD_TICK:
                            begin
                                ctrl.load       = 1'b1;
                                ctrl.tick_check = 1'b1;
                                tick_now_next   = ctrl.tick_next;
                                state_next      = prtt_pkg::S_APPLY;
                            end
                            prtt_pkg::CMD_CLEAR:
                            begin
                                ctrl.clear = 1'b1;
                            end
                            default:
                            begin
                                state_next = prtt_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            prtt_pkg::S_APPLY:
            begin
                ctrl.apply = 1'b1;
                state_next = prtt_pkg::S_DRAIN;
            end
            default:
            begin
                state_next = prtt_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= prtt_pkg::S_IDLE;
            strobe_reg   <= 1'b0;
            tick_now_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            strobe_reg   <= strobe_next;
            tick_now_reg <= tick_now_next;
        end
    end

    // result beat and reply type flag
    always_ff @(posedge clk)
    begin
        result_reg       <= result_next;
        reply_online_reg <= reply_online_next;
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    // a refused insert is a single beat
    `PRTT_ASSERT_IMP(a_refused_single, clk, rst_n,
        result_strobe && result.result_kind == prtt_pkg::KIND_REFUSED, result.last)
    // a run of retirements has no gaps
    `PRTT_ASSERT_NXT(a_run_continues, clk, rst_n,
        result_strobe && !result.last, result_strobe)
    // a beat that is not the last of its item leaves the sequencer draining
    `PRTT_ASSERT_IMP(a_run_draining, clk, rst_n,
        result_strobe && !result.last, state_reg == prtt_pkg::S_DRAIN)
    // no new item while the cells update
    `PRTT_ASSERT_IMP(a_apply_busy, clk, rst_n,
        state_reg == prtt_pkg::S_APPLY, busy && !result_strobe)

endmodule

`default_nettype wire

// ----- dv/tb_probe_reply_tracking_table_core.sv -----
// testbench for the probe reply tracking table core, with a scoreboard predicting every result beat
module tb_probe_reply_tracking_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import prtt_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int WATCH_MAX = 2000;
    localparam int SETTLE    = 8;

    // table predictor and store of outstanding result beats
    class track_table_checker;
        logic [ADDR_W-1:0] slot_host  [TABLE_DEPTH_DEF];
        status_t           slot_state [TABLE_DEPTH_DEF];
        logic [TICK_W-1:0] slot_stamp [TABLE_DEPTH_DEF];
        int unsigned       oldest;
        int unsigned       live;
        logic [TICK_W-1:0] now_tick;
        logic [TICK_W-1:0] age_limit;
        logic [LEN_W-1:0]  match_len;
        result_t           due_beats [$];
        int                errors;

        function new();
            oldest    = 0;
            live      = 0;
            now_tick  = '0;
            age_limit = TIMEOUT_RESET;
            match_len = REPLY_LEN_RESET;
            errors    = 0;
        endfunction

        function result_t make_beat(logic kind, logic [ADDR_W-1:0] host, logic online);
            result_t beat;
            beat.result_kind     = kind;
            beat.retired_address = host;
            beat.host_online     = online;
            beat.last            = 1'b0;
            return beat;
        endfunction

        // apply one accepted beat
        function void apply_item(item_t it);
            result_t           fresh [$];
            int unsigned       slot;
            logic [TICK_W-1:0] age;
            case (it.command)
                CMD_INSERT:
                begin
                    if (live >= DEPTH)
                        fresh = {fresh, make_beat(KIND_REFUSED, it.host_address, 1'b0)};
                    else
                    begin
                        slot             = (oldest + live) % DEPTH;
                        slot_host[slot]  = it.host_address;
                        slot_stamp[slot] = now_tick;
                        slot_state[slot] = ST_PENDING;
                        live++;
                    end
                end
                CMD_REPLY:
                begin
                    // oldest entry of the replier decides, settled or not
                    if (it.reply_length == match_len)
                    begin
                        for (int i = 0; i < live; i++)
                        begin
                            slot = (oldest + i) % DEPTH;
                            if (slot_host[slot] == it.host_address)
                            begin
                                if (slot_state[slot] == ST_PENDING)
                                begin
                                    slot_state[slot] = (it.reply_type == ICMP_ECHO_REPLY) ?
                                                       ST_ONLINE : ST_OFFLINE;
                                end
                                break;
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    // ages wrap modulo the tick width
                    now_tick = now_tick + 1'b1;
                    for (int i = 0; i < live; i++)
                    begin
                        slot = (oldest + i) % DEPTH;
                        age  = now_tick - slot_stamp[slot];
                        if (slot_state[slot] == ST_PENDING && age >= age_limit)
                            slot_state[slot] = ST_OFFLINE;
                    end
                end
                default:
                begin
                    live   = 0;
                    oldest = 0;
                end
            endcase
            // settled entries leave from the head in send order
            while (live > 0 && slot_state[oldest] != ST_PENDING)
            begin
                fresh = {fresh, make_beat(KIND_RETIRED, slot_host[oldest],
                                          slot_state[oldest] == ST_ONLINE)};
                oldest = (oldest + 1) % DEPTH;
                live--;
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            due_beats = {due_beats, fresh};
        endfunction

        function void report(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        endfunction

        // compare one result beat with the oldest outstanding one
        function void check_beat(result_t got);
            result_t want;
            if (due_beats.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                         $time, got);
                return;
            end
            want = due_beats.pop_front();
            if (got.result_kind !== want.result_kind)
                report("result_kind", want.result_kind, got.result_kind);
            if (got.retired_address !== want.retired_address)
                report("retired_address", want.retired_address, got.retired_address);
            if (got.host_online !== want.host_online)
                report("host_online", want.host_online, got.host_online);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    result_t               result;
    logic                  result_strobe;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    track_table_checker sb;
    int                 applied_items = 0;
    int                 sender_idle_pct = 0;
    int                 quiet_cycles = 0;

    probe_reply_tracking_table_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result        (result),
        .result_strobe (result_strobe),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // monitor: accepted input beats and result beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_strobe)
                sb.check_beat(result);
            if (start && !busy)
            begin
                sb.apply_item(item);
                applied_items++;
            end
        end
    end

    // watchdog on cycles with no beat of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCH_MAX);
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one input beat and hold it until taken
    task automatic send(input cmd_t cmd, input logic [ADDR_W-1:0] host,
                        input logic [LEN_W-1:0] len, input logic [TYPE_W-1:0] icmp);
        item_t beat;
        beat.command      = cmd;
        beat.host_address = host;
        beat.reply_length = len;
        beat.reply_type   = icmp;
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // hold off until every outstanding beat has come and the core is quiet
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.due_beats.size() != 0 || busy);
        repeat (SETTLE) @(posedge clk);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_reg(input logic reg_sel, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_TIMEOUT)
            sb.age_limit = value;
        else
            sb.match_len = value[LEN_W-1:0];
        @(posedge clk);
    endtask

    // random stretch under one register setting
    task automatic run_phase(input logic [TICK_W-1:0] tmo, input logic [LEN_W-1:0] rlen,
                             input int idle_pct, input int quota, input bit flood);
        logic [ADDR_W-1:0] hosts [8];
        int                first;
        int                n;
        drain();
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_REPLY_LEN, {16'h0, rlen});
        sender_idle_pct = idle_pct;
        foreach (hosts[i])
            hosts[i] = $urandom;
        hosts[0] = '0;
        hosts[1] = '1;
        first = applied_items;
        // overfill the table, then let the whole row time out together
        if (flood)
        begin
            repeat (DEPTH + 3)
                send(CMD_INSERT, hosts[$urandom_range(7)], 16'($urandom), 8'($urandom));
            repeat (6) send(CMD_TICK, $urandom, 16'($urandom), 8'($urandom));
        end
        while (applied_items - first < quota)
        begin
            n = $urandom_range(1, 6);
            case ($urandom_range(9))
                0, 1:
                    // noise
                    repeat (n)
                        send(cmd_t'(2'($urandom_range(3))), $urandom, 16'($urandom),
                             8'($urandom));
                2:
                begin
                    // probes left unanswered, or a pause until everything is out
                    if ($urandom_range(3) == 0)
                        drain();
                    repeat (n)
                        send(CMD_INSERT, hosts[$urandom_range(7)], 16'($urandom),
                             8'($urandom));
                    repeat ($urandom_range(1, 3))
                        send(CMD_TICK, $urandom, 16'($urandom), 8'($urandom));
                end
                default:
                begin
                    // probes followed by matching replies and the odd tick
                    repeat (n)
                        send(CMD_INSERT, hosts[$urandom_range(7)], 16'($urandom),
                             8'($urandom));
                    repeat (n + 2)
                    begin
                        if ($urandom_range(9) < 7)
                            send(CMD_REPLY, hosts[$urandom_range(7)], rlen,
                                 ($urandom_range(3) != 0) ? ICMP_ECHO_REPLY : 8'($urandom));
                        else
                            send(CMD_TICK, $urandom, 16'($urandom), 8'($urandom));
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default registers
        send(CMD_INSERT, 32'h0000_0000, 16'h0000, 8'h00);
        send(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send(CMD_INSERT, 32'hA5A5_5A5A, 16'h1234, 8'h5A);
        send(CMD_REPLY, 32'hFFFF_FFFF, 16'd28, ICMP_ECHO_REPLY);
        // already settled entry keeps its status
        send(CMD_REPLY, 32'hFFFF_FFFF, 16'd28, 8'd8);
        // wrong length, then unknown host
        send(CMD_REPLY, 32'h0000_0000, 16'd27, ICMP_ECHO_REPLY);
        send(CMD_REPLY, 32'h1234_5678, 16'd28, ICMP_ECHO_REPLY);
        // non-echo type takes the head offline, two entries retire
        send(CMD_REPLY, 32'h0000_0000, 16'd28, 8'hFF);
        send(CMD_INSERT, 32'hA5A5_5A5A, 16'h0000, 8'h00);
        send(CMD_REPLY, 32'hA5A5_5A5A, 16'd28, ICMP_ECHO_REPLY);
        send(CMD_TICK, 32'h0, 16'h0, 8'h0);
        send(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send(CMD_REPLY, 32'hA5A5_5A5A, 16'd28, ICMP_ECHO_REPLY);

        // directed: shortest timeout, longest reply length
        drain();
        write_reg(REG_TIMEOUT, 32'd1);
        write_reg(REG_REPLY_LEN, 32'd65535);
        send(CMD_INSERT, 32'h0000_0000, 16'h0, 8'h0);
        send(CMD_INSERT, 32'hFFFF_FFFF, 16'h0, 8'h0);
        send(CMD_REPLY, 32'hFFFF_FFFF, 16'hFFFF, ICMP_ECHO_REPLY);
        send(CMD_TICK, 32'h0, 16'h0, 8'h0);
        send(CMD_INSERT, 32'h5A5A_A5A5, 16'h0, 8'h0);
        send(CMD_TICK, 32'h0, 16'h0, 8'h0);

        // directed: zero reply length
        drain();
        write_reg(REG_REPLY_LEN, 32'd0);
        send(CMD_INSERT, 32'h0000_0001, 16'h0, 8'h0);
        send(CMD_REPLY, 32'h0000_0001, 16'h0, ICMP_ECHO_REPLY);
        send(CMD_INSERT, 32'h8000_0000, 16'h0, 8'h0);
        send(CMD_CLEAR, 32'h0, 16'h0, 8'h0);

        // random phases
        run_phase(32'd4, 16'd28, 0, 60, 1'b1);
        run_phase(32'd1, 16'd0, 49, 35, 1'b0);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 0, 35, 1'b0);
        run_phase(32'($urandom_range(2, 16)), 16'($urandom), 21, 35, 1'b0);

        drain();
        if (sb.due_beats.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d result beats never arrived", $time, sb.due_beats.size());
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/prtt_pkg.sv
rtl/prtt_cell.sv
rtl/prtt_regs.sv
rtl/probe_reply_tracking_table_core.sv
dv/tb_probe_reply_tracking_table_core.sv
